>>> sv/ccrn_pkg.sv
`timescale 1ns / 1ps

package ccrn_pkg;

    // default sizes
    localparam int FRAME_DEPTH_DEFAULT   = 65536;
    localparam int OUT_FRAC_BITS_DEFAULT = 12;

    // (2x+1)*crop stays below 2^27 for 10-bit x and 16-bit crop
    localparam int NUM_W       = 27;
    localparam int RECIP_SHIFT = 27;
    localparam int DIV_STEPS   = RECIP_SHIFT + 1;

    localparam logic [15:0] SOURCE_WIDTH_RESET  = 16'd256;
    localparam logic [15:0] SOURCE_HEIGHT_RESET = 16'd256;
    localparam logic [10:0] TARGET_SIZE_RESET   = 11'd224;

    typedef enum logic [1:0] {
        REG_SOURCE_WIDTH  = 2'd0,
        REG_SOURCE_HEIGHT = 2'd1,
        REG_TARGET_SIZE   = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CHAN_RED   = 2'd0,
        CHAN_GREEN = 2'd1,
        CHAN_BLUE  = 2'd2
    } chan_t;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_FETCH = 1'b1;

    // channel statistics scaled by 1e8
    localparam longint DEC_ONE      = 64'd100000000;
    localparam longint CHAN_MEAN_R  = 64'd48145466;
    localparam longint CHAN_MEAN_G  = 64'd45782750;
    localparam longint CHAN_MEAN_B  = 64'd40821073;
    localparam longint CHAN_STD_R   = 64'd26862954;
    localparam longint CHAN_STD_G   = 64'd26130258;
    localparam longint CHAN_STD_B   = 64'd27577711;
    localparam longint NORM_DEN2_R  = 2 * 255 * CHAN_STD_R;
    localparam longint NORM_DEN2_G  = 2 * 255 * CHAN_STD_G;
    localparam longint NORM_DEN2_B  = 2 * 255 * CHAN_STD_B;

    typedef struct packed {
        logic        kind;
        logic [15:0] load_index;
        logic [7:0]  load_red;
        logic [7:0]  load_green;
        logic [7:0]  load_blue;
        logic [9:0]  out_x;
        logic [9:0]  out_y;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] norm_red;
        logic signed [15:0] norm_green;
        logic signed [15:0] norm_blue;
        logic        [15:0] source_index;
        logic               coord_error;
    } out_item_t;

    // geometry derived from the configuration registers
    typedef struct packed {
        logic [15:0] w_eff;
        logic [15:0] w_max;
        logic [15:0] h_max;
        logic [14:0] off_x;
        logic [14:0] off_y;
        logic [15:0] crop;
        logic [10:0] t_eff;
        logic [11:0] dvsr;
        logic [26:0] recip;
    } setup_t;

    // one access of the frame store
    typedef struct packed {
        logic        valid;
        logic        fetch;
        logic        hit;
        logic        coord_error;
        logic [15:0] src_index;
        logic [23:0] pixel;
    } mem_req_t;

    // normalized value of one channel byte, evaluated at elaboration
    function automatic logic [15:0] norm_entry(input logic [7:0] v, input chan_t chan,
                                               input int frac);
        longint num;
        longint den;
        longint mag;
        longint q;
        longint r;
        logic   neg;
        num = 0;
        den = 1;
        q   = 0;
        unique case (chan)
            CHAN_RED:   begin num = longint'(v) * DEC_ONE - 255 * CHAN_MEAN_R;
                              den = 255 * CHAN_STD_R; end
            CHAN_GREEN: begin num = longint'(v) * DEC_ONE - 255 * CHAN_MEAN_G;
                              den = 255 * CHAN_STD_G; end
            CHAN_BLUE:  begin num = longint'(v) * DEC_ONE - 255 * CHAN_MEAN_B;
                              den = 255 * CHAN_STD_B; end
            default:    begin num = 0; den = 1; end
        endcase
        neg = (num < 0);
        mag = neg ? -num : num;
        unique case (chan)
            CHAN_RED:   q = ((mag <<< (frac + 1)) + den) / NORM_DEN2_R;
            CHAN_GREEN: q = ((mag <<< (frac + 1)) + den) / NORM_DEN2_G;
            CHAN_BLUE:  q = ((mag <<< (frac + 1)) + den) / NORM_DEN2_B;
            default:    q = 0;
        endcase
        if (neg)
            r = (q > 32768) ? -32768 : -q;
        else
            r = (q > 32767) ? 32767 : q;
        return 16'(r);
    endfunction

endpackage

>>> sv/ccrn_setup.sv
`timescale 1ns / 1ps

module ccrn_setup (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    output ccrn_pkg::setup_t    setup,
    output logic                ready
);

    logic [15:0] width_reg;
    logic [15:0] height_reg;
    logic [10:0] target_reg;

    logic [15:0] w_eff;
    logic [15:0] h_eff;
    logic [15:0] crop;
    logic [10:0] t_eff;
    logic [11:0] dvsr;

    ccrn_pkg::setup_t setup_reg;
    ccrn_pkg::setup_t setup_next;

    logic        busy_reg;
    logic        ready_reg;
    logic [4:0]  step_reg;
    logic [11:0] rem_reg;
    logic [11:0] rem_next;
    logic [26:0] quo_reg;
    logic [26:0] quo_next;
    logic [12:0] trial;
    logic        ge;
    logic        cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= ccrn_pkg::SOURCE_WIDTH_RESET;
            height_reg <= ccrn_pkg::SOURCE_HEIGHT_RESET;
            target_reg <= ccrn_pkg::TARGET_SIZE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                ccrn_pkg::REG_SOURCE_WIDTH:  width_reg  <= cfg_data;
                ccrn_pkg::REG_SOURCE_HEIGHT: height_reg <= cfg_data;
                ccrn_pkg::REG_TARGET_SIZE:   target_reg <= cfg_data[10:0];
                default:                     ;
            endcase
        end
    end

    // zero sizes act as one
    always_comb
    begin
        w_eff = (width_reg == 16'd0) ? 16'd1 : width_reg;
        h_eff = (height_reg == 16'd0) ? 16'd1 : height_reg;
        t_eff = (target_reg == 11'd0) ? 11'd1 : target_reg;
        crop  = (w_eff < h_eff) ? w_eff : h_eff;
        dvsr  = {t_eff, 1'b0};

        setup_next.w_eff = w_eff;
        setup_next.w_max = w_eff - 16'd1;
        setup_next.h_max = h_eff - 16'd1;
        setup_next.off_x = 15'((w_eff - crop) >> 1);
        setup_next.off_y = 15'((h_eff - crop) >> 1);
        setup_next.crop  = crop;
        setup_next.t_eff = t_eff;
        setup_next.dvsr  = dvsr;
        setup_next.recip = quo_reg;
    end

    always_ff @(posedge clk)
    begin
        setup_reg <= setup_next;
    end

    // restoring division of 2^27 by 2*target, one quotient bit per cycle
    always_comb
    begin
        trial    = {rem_reg, (step_reg == 5'(ccrn_pkg::DIV_STEPS - 1))};
        ge       = (trial >= {1'b0, dvsr});
        rem_next = ge ? 12'(trial - {1'b0, dvsr}) : trial[11:0];
        quo_next = {quo_reg[25:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b1;
            ready_reg <= 1'b0;
            step_reg  <= 5'(ccrn_pkg::DIV_STEPS - 1);
            rem_reg   <= 12'd0;
        end
        else
        begin
            ready_reg <= !busy_reg;
            if (cfg_write)
            begin
                busy_reg <= 1'b1;
                step_reg <= 5'(ccrn_pkg::DIV_STEPS - 1);
                rem_reg  <= 12'd0;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                if (step_reg == 5'd0)
                    busy_reg <= 1'b0;
                else
                    step_reg <= step_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && !cfg_write)
            quo_reg <= quo_next;
    end

    assign setup = setup_reg;
    assign ready = ready_reg && !busy_reg;

endmodule

>>> sv/ccrn_map.sv
`timescale 1ns / 1ps

module ccrn_map #(
    parameter int FRAME_DEPTH = ccrn_pkg::FRAME_DEPTH_DEFAULT,
    parameter int ADDR_W      = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                accept,
    input  ccrn_pkg::in_item_t  item,
    input  ccrn_pkg::setup_t    setup,
    output ccrn_pkg::mem_req_t  req,
    output logic [ADDR_W-1:0]   addr
);

    localparam logic [32:0] DEPTH_W = 33'(FRAME_DEPTH);

    // per-stage valid and kind
    logic        s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic        s1_fetch_reg, s2_fetch_reg, s3_fetch_reg, s4_fetch_reg, s5_fetch_reg;
    logic        s1_cerr_reg,  s2_cerr_reg,  s3_cerr_reg,  s4_cerr_reg,  s5_cerr_reg;
    logic [15:0] s1_lidx_reg,  s2_lidx_reg,  s3_lidx_reg,  s4_lidx_reg,  s5_lidx_reg;
    logic [23:0] s1_pix_reg,   s2_pix_reg,   s3_pix_reg,   s4_pix_reg,   s5_pix_reg;

    // coordinate datapath
    logic [26:0] s1_nx_reg, s1_ny_reg, s2_nx_reg, s2_ny_reg, s3_nx_reg, s3_ny_reg;
    logic [26:0] nx_next, ny_next;
    logic        cerr_next;
    logic [53:0] s2_px_reg, s2_py_reg;
    logic [26:0] qx, qy;
    logic [38:0] mx_full, my_full;
    logic [26:0] s3_qx_reg, s3_qy_reg, s3_mx_reg, s3_my_reg;
    logic [26:0] rx, ry, qcx, qcy;
    logic [27:0] sx_wide, sy_wide;
    logic [15:0] sx_next, sy_next;
    logic [15:0] s4_sx_reg, s4_sy_reg, s5_sx_reg;
    logic [31:0] s5_prod_reg;
    logic [31:0] idx, sel;

    ccrn_pkg::mem_req_t req_reg;
    ccrn_pkg::mem_req_t req_next;
    logic [ADDR_W-1:0]  addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            req_reg       <= '0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= accept;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            req_reg       <= req_next;
        end
    end

    // stage 1: numerators (2x+1)*crop, range check
    always_comb
    begin
        nx_next   = {16'd0, item.out_x, 1'b1} * {11'd0, setup.crop};
        ny_next   = {16'd0, item.out_y, 1'b1} * {11'd0, setup.crop};
        cerr_next = ({1'b0, item.out_x} >= setup.t_eff) || ({1'b0, item.out_y} >= setup.t_eff);
    end

    // stage 3: quotient estimate times divisor
    always_comb
    begin
        qx      = s2_px_reg[53:27];
        qy      = s2_py_reg[53:27];
        mx_full = {12'd0, qx} * {27'd0, setup.dvsr};
        my_full = {12'd0, qy} * {27'd0, setup.dvsr};
    end

    // stage 4: one-step correction, offset and clamp
    always_comb
    begin
        rx      = s3_nx_reg - s3_mx_reg;
        ry      = s3_ny_reg - s3_my_reg;
        qcx     = s3_qx_reg + 27'(rx >= {15'd0, setup.dvsr});
        qcy     = s3_qy_reg + 27'(ry >= {15'd0, setup.dvsr});
        sx_wide = {13'd0, setup.off_x} + {1'b0, qcx};
        sy_wide = {13'd0, setup.off_y} + {1'b0, qcy};
        sx_next = (sx_wide > {12'd0, setup.w_max}) ? setup.w_max : sx_wide[15:0];
        sy_next = (sy_wide > {12'd0, setup.h_max}) ? setup.h_max : sy_wide[15:0];
    end

    // stage 6: raster index and store address
    always_comb
    begin
        idx                  = s5_prod_reg + {16'd0, s5_sx_reg};
        sel                  = s5_fetch_reg ? idx : {16'd0, s5_lidx_reg};
        req_next             = req_reg;
        req_next.valid       = s5_valid_reg;
        req_next.fetch       = s5_fetch_reg;
        req_next.hit         = ({1'b0, sel} < DEPTH_W);
        req_next.coord_error = s5_cerr_reg;
        req_next.src_index   = idx[15:0];
        req_next.pixel       = s5_pix_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_fetch_reg <= (item.kind == ccrn_pkg::KIND_FETCH);
            s1_cerr_reg  <= cerr_next;
            s1_lidx_reg  <= item.load_index;
            s1_pix_reg   <= {item.load_red, item.load_green, item.load_blue};
            s1_nx_reg    <= nx_next;
            s1_ny_reg    <= ny_next;

            s2_fetch_reg <= s1_fetch_reg;
            s2_cerr_reg  <= s1_cerr_reg;
            s2_lidx_reg  <= s1_lidx_reg;
            s2_pix_reg   <= s1_pix_reg;
            s2_nx_reg    <= s1_nx_reg;
            s2_ny_reg    <= s1_ny_reg;
            s2_px_reg    <= {27'd0, s1_nx_reg} * {27'd0, setup.recip};
            s2_py_reg    <= {27'd0, s1_ny_reg} * {27'd0, setup.recip};

            s3_fetch_reg <= s2_fetch_reg;
            s3_cerr_reg  <= s2_cerr_reg;
            s3_lidx_reg  <= s2_lidx_reg;
            s3_pix_reg   <= s2_pix_reg;
            s3_nx_reg    <= s2_nx_reg;
            s3_ny_reg    <= s2_ny_reg;
            s3_qx_reg    <= qx;
            s3_qy_reg    <= qy;
            s3_mx_reg    <= mx_full[26:0];
            s3_my_reg    <= my_full[26:0];

            s4_fetch_reg <= s3_fetch_reg;
            s4_cerr_reg  <= s3_cerr_reg;
            s4_lidx_reg  <= s3_lidx_reg;
            s4_pix_reg   <= s3_pix_reg;
            s4_sx_reg    <= sx_next;
            s4_sy_reg    <= sy_next;

            s5_fetch_reg <= s4_fetch_reg;
            s5_cerr_reg  <= s4_cerr_reg;
            s5_lidx_reg  <= s4_lidx_reg;
            s5_pix_reg   <= s4_pix_reg;
            s5_sx_reg    <= s4_sx_reg;
            s5_prod_reg  <= {16'd0, s4_sy_reg} * {16'd0, setup.w_eff};

            addr_reg            <= sel[ADDR_W-1:0];
        end
    end

    assign req  = req_reg;
    assign addr = addr_reg;

endmodule

>>> sv/ccrn_store.sv
`timescale 1ns / 1ps

module ccrn_store #(
    parameter int FRAME_DEPTH   = ccrn_pkg::FRAME_DEPTH_DEFAULT,
    parameter int OUT_FRAC_BITS = ccrn_pkg::OUT_FRAC_BITS_DEFAULT,
    parameter int ADDR_W        = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  ccrn_pkg::mem_req_t  req,
    input  logic [ADDR_W-1:0]   addr,
    output logic                result_valid,
    output ccrn_pkg::out_item_t result
);

    logic [23:0] frame_mem [FRAME_DEPTH];
    logic [23:0] rd_reg;

    logic        s7_valid_reg;
    logic        s7_hit_reg;
    logic        s7_cerr_reg;
    logic [15:0] s7_src_reg;
    logic [23:0] pix;

    logic        result_valid_reg;
    ccrn_pkg::out_item_t result_reg;
    ccrn_pkg::out_item_t result_next;

    logic [15:0] lut_red   [256];
    logic [15:0] lut_green [256];
    logic [15:0] lut_blue  [256];

    for (genvar gi = 0; gi < 256; gi++)
    begin : g_lut
        assign lut_red[gi]   = ccrn_pkg::norm_entry(8'(gi), ccrn_pkg::CHAN_RED, OUT_FRAC_BITS);
        assign lut_green[gi] = ccrn_pkg::norm_entry(8'(gi), ccrn_pkg::CHAN_GREEN, OUT_FRAC_BITS);
        assign lut_blue[gi]  = ccrn_pkg::norm_entry(8'(gi), ccrn_pkg::CHAN_BLUE, OUT_FRAC_BITS);
    end

    // single port: each item is either one write or one read, in arrival order
    always_ff @(posedge clk)
    begin
        if (adv && req.valid && req.hit && !req.fetch)
            frame_mem[addr] <= req.pixel;
    end

    always_ff @(posedge clk)
    begin
        if (adv && req.valid && req.hit && req.fetch)
            rd_reg <= frame_mem[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s7_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s7_valid_reg     <= req.valid && req.fetch;
            result_valid_reg <= s7_valid_reg;
        end
    end

    // index past the store reads as zero
    always_comb
    begin
        pix                     = s7_hit_reg ? rd_reg : 24'd0;
        result_next.norm_red    = $signed(lut_red[pix[23:16]]);
        result_next.norm_green  = $signed(lut_green[pix[15:8]]);
        result_next.norm_blue   = $signed(lut_blue[pix[7:0]]);
        result_next.source_index = s7_src_reg;
        result_next.coord_error = s7_cerr_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s7_hit_reg  <= req.hit;
            s7_cerr_reg <= req.coord_error;
            s7_src_reg  <= req.src_index;
            result_reg  <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

>>> sv/center_crop_resize_normalize_core.sv
`timescale 1ns / 1ps

// center crop, nearest-neighbor resize and mean/std normalization of rgb pixels.
// load items (kind 0) write one pixel into the frame store and give no result;
// fetch items (kind 1) return one normalized pixel in signed fixed point with
// OUT_FRAC_BITS fraction bits. the block takes one item per cycle while item_stall
// is low. a fetch passes the map stages, the store request register, the store
// read register and the output register before its result_valid rises, and a
// stalled result holds the whole pipeline. after reset and after every
// configuration write the reciprocal of 2*target_size is rebuilt by a bit-serial
// divider, and item_stall stays high until the new quotient is registered. the
// frame store is not cleared: fetching a never loaded entry returns undefined data.

module center_crop_resize_normalize_core #(
    parameter int FRAME_DEPTH   = ccrn_pkg::FRAME_DEPTH_DEFAULT,
    parameter int OUT_FRAC_BITS = ccrn_pkg::OUT_FRAC_BITS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,

    // item channel
    input  logic                item_valid,
    output logic                item_stall,
    input  ccrn_pkg::in_item_t  item,

    // result channel
    output logic                result_valid,
    input  logic                result_stall,
    output ccrn_pkg::out_item_t result,

    // configuration writes
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data
);

    // store address width, at least one bit
    localparam int ADDR_W = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;

    ccrn_pkg::setup_t   setup;
    ccrn_pkg::mem_req_t req;
    logic [ADDR_W-1:0]  addr;
    logic               ready;
    logic               adv;
    logic               accept;

    // the pipeline moves as one while the output register is free or drained
    assign adv        = !result_valid || !result_stall;
    assign item_stall = !adv || !ready;
    assign accept     = item_valid && !item_stall;

    // configuration registers, crop geometry, reciprocal divider
    ccrn_setup u_setup (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .setup     (setup),
        .ready     (ready)
    );

    // coordinate mapping: numerator, reciprocal multiply, correction, raster index
    ccrn_map #(
        .FRAME_DEPTH (FRAME_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_map (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .accept (accept),
        .item   (item),
        .setup  (setup),
        .req    (req),
        .addr   (addr)
    );

    // frame store access, normalization tables, output register
    ccrn_store #(
        .FRAME_DEPTH   (FRAME_DEPTH),
        .OUT_FRAC_BITS (OUT_FRAC_BITS),
        .ADDR_W        (ADDR_W)
    ) u_store (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .req          (req),
        .addr         (addr),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

>>> sv/ccrn_checker.sv
`timescale 1ns / 1ps

module ccrn_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                item_valid,
    input logic                item_stall,
    input ccrn_pkg::in_item_t  item,
    input logic                result_valid,
    input logic                result_stall,
    input ccrn_pkg::out_item_t result,
    input logic                cfg_valid,
    input logic                cfg_ready,
    input logic [1:0]          cfg_index,
    input logic [15:0]         cfg_data
);

    // a stalled result keeps its valid
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result valid dropped while stalled");

    // a stalled result keeps its payload
    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("result payload changed while stalled");

    // a blocked output stops new items
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |-> item_stall)
        else $error("item taken while result blocked");

    // geometry rebuild after a configuration transfer blocks items
    a_cfg_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> item_stall)
        else $error("item taken during geometry rebuild");

endmodule

bind center_crop_resize_normalize_core ccrn_checker u_checker (.*);

>>> bench/crop_norm_checker.sv
`timescale 1ns / 1ps

module crop_norm_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  logic                item_stall,
    input  ccrn_pkg::in_item_t  item,
    input  logic                result_valid,
    input  logic                result_stall,
    input  ccrn_pkg::out_item_t result,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    output int                  mismatch_count,
    output int                  pending_results
);
    import ccrn_pkg::*;

    localparam int     FRAC        = OUT_FRAC_BITS_DEFAULT;
    localparam longint STORE_DEPTH = FRAME_DEPTH_DEFAULT;

    logic [23:0] pixel_mem [0:65535];
    logic [15:0] width_reg;
    logic [15:0] height_reg;
    logic [10:0] target_reg;
    out_item_t   expected_q [$];
    int          fail_total = 0;

    assign mismatch_count = fail_total;

    // one axis of the centered crop, nearest neighbor, clamped to the image
    function automatic longint axis_pick(input longint pos, input longint extent,
                                         input longint crop, input longint tsize);
        longint s;
        s = (extent - crop) / 2 + ((2 * pos + 1) * crop) / (2 * tsize);
        return (s > extent - 1) ? extent - 1 : s;
    endfunction

    // full raster index of the chosen source pixel, not truncated
    function automatic longint crop_source_index(input logic [15:0] w_raw,
                                                 input logic [15:0] h_raw,
                                                 input logic [10:0] t_raw,
                                                 input logic [9:0]  col,
                                                 input logic [9:0]  row);
        longint w;
        longint h;
        longint t;
        longint crop;
        w    = (w_raw == 0) ? 1 : longint'(w_raw);
        h    = (h_raw == 0) ? 1 : longint'(h_raw);
        t    = (t_raw == 0) ? 1 : longint'(t_raw);
        crop = (w < h) ? w : h;
        return axis_pick(row, h, crop, t) * w + axis_pick(col, w, crop, t);
    endfunction

    // (v/255 - mean) / std in fixed point, half away from zero, saturated
    function automatic logic signed [15:0] norm_channel(input logic [7:0] v,
                                                        input chan_t chan);
        longint mean;
        longint dev;
        longint num;
        longint den;
        longint mag;
        longint q;
        case (chan)
            CHAN_RED:
            begin
                mean = CHAN_MEAN_R;
                dev  = CHAN_STD_R;
            end
            CHAN_GREEN:
            begin
                mean = CHAN_MEAN_G;
                dev  = CHAN_STD_G;
            end
            default:
            begin
                mean = CHAN_MEAN_B;
                dev  = CHAN_STD_B;
            end
        endcase
        num = longint'(v) * DEC_ONE - 255 * mean;
        den = 255 * dev;
        mag = (num < 0) ? -num : num;
        q   = ((mag << (FRAC + 1)) + den) / (2 * den);
        if (num < 0)
            q = (q > 32768) ? -32768 : -q;
        else
            q = (q > 32767) ? 32767 : q;
        return 16'(q);
    endfunction

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_total++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        out_item_t   due;
        longint      src;
        logic [23:0] px;
        logic [10:0] t_eff;
        if (!rst_n)
        begin
            width_reg  = SOURCE_WIDTH_RESET;
            height_reg = SOURCE_HEIGHT_RESET;
            target_reg = TARGET_SIZE_RESET;
            expected_q.delete();
            pending_results <= 0;
        end
        else
        begin
            // results first: an item taken at this edge cannot answer here
            if (result_valid && !result_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("source_index: expected nothing, got %0d", result.source_index);
                    fail_total++;
                end
                else
                begin
                    due = expected_q.pop_front();
                    check_field("norm_red", due.norm_red, result.norm_red);
                    check_field("norm_green", due.norm_green, result.norm_green);
                    check_field("norm_blue", due.norm_blue, result.norm_blue);
                    check_field("source_index", due.source_index, result.source_index);
                    check_field("coord_error", due.coord_error, result.coord_error);
                end
            end
            if (item_valid && !item_stall)
            begin
                if (item.kind == KIND_LOAD)
                    pixel_mem[item.load_index] = {item.load_red, item.load_green,
                                                  item.load_blue};
                else
                begin
                    src   = crop_source_index(width_reg, height_reg, target_reg,
                                              item.out_x, item.out_y);
                    px    = (src < STORE_DEPTH) ? pixel_mem[src[15:0]] : 24'h0;
                    t_eff = (target_reg == 0) ? 11'd1 : target_reg;
                    due.norm_red     = norm_channel(px[23:16], CHAN_RED);
                    due.norm_green   = norm_channel(px[15:8], CHAN_GREEN);
                    due.norm_blue    = norm_channel(px[7:0], CHAN_BLUE);
                    due.source_index = src[15:0];
                    due.coord_error  = (item.out_x >= t_eff) || (item.out_y >= t_eff);
                    expected_q.insert(expected_q.size(), due);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SOURCE_WIDTH:  width_reg  = cfg_data;
                    REG_SOURCE_HEIGHT: height_reg = cfg_data;
                    REG_TARGET_SIZE:   target_reg = cfg_data[10:0];
                    default:           ;
                endcase
            end
            pending_results <= expected_q.size();
        end
    end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ccrn_pkg::*;

    localparam int         CLK_HALF         = 4;
    localparam int         RESET_CYCLES     = 3;
    localparam int         MAX_GAP          = 19;
    // receiver hold-off long enough to back the pipeline up into the input
    localparam int         LONG_HOLD_CYCLES = 300;
    // loads give no result, so let the pipeline empty before touching registers
    localparam int         DRAIN_CYCLES     = 16;
    // cycles without any transfer before the run is declared hung
    localparam int         WATCHDOG_LIMIT   = 2000;
    localparam int         RANDOM_PHASES    = 10;
    // items per phase, counting the loads that fetches pull in
    localparam int         ITEMS_PER_PHASE  = 38;
    localparam int         LOAD_PERCENT     = 30;
    localparam int         OUTSIDE_PERCENT  = 15;
    // index past the register list, must be ignored
    localparam logic [1:0] REG_UNUSED       = 2'd3;

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      item_valid   = 1'b0;
    logic      item_stall;
    in_item_t  item         = '0;
    logic      result_valid;
    logic      result_stall = 1'b0;
    out_item_t result;
    logic        cfg_valid  = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index  = 2'd0;
    logic [15:0] cfg_data   = 16'd0;
    int          mismatch_count;
    int          pending_results;
    int          items_sent = 0;

    // stimulus-side copy of the registers, used to steer fetches onto loaded pixels
    logic [15:0] width_shadow  = SOURCE_WIDTH_RESET;
    logic [15:0] height_shadow = SOURCE_HEIGHT_RESET;
    logic [10:0] target_shadow = TARGET_SIZE_RESET;
    bit          loaded [0:65535];

    // no random gaps on either side while set
    bit calm         = 1'b0;
    int holds_wanted = 0;
    int holds_done   = 0;

    center_crop_resize_normalize_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    crop_norm_checker i_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .item            (item),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .result          (result),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // offer one item after a random gap and hold it until its transfer;
    // valid stays high across back-to-back items
    task automatic send_item(input in_item_t it);
        int gap;
        gap = calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        do @(posedge clk); while (!(item_valid && !item_stall));
        items_sent++;
    endtask

    // fetch fields carry noise on a load, so every bit still toggles
    task automatic load_pixel(input logic [15:0] at, input logic [23:0] rgb);
        in_item_t it;
        it.kind       = KIND_LOAD;
        it.load_index = at;
        it.load_red   = rgb[23:16];
        it.load_green = rgb[15:8];
        it.load_blue  = rgb[7:0];
        it.out_x      = 10'($urandom());
        it.out_y      = 10'($urandom());
        loaded[at]    = 1'b1;
        send_item(it);
    endtask

    function automatic longint chosen_index(input logic [9:0] col, input logic [9:0] row);
        return i_check.crop_source_index(width_shadow, height_shadow, target_shadow,
                                         col, row);
    endfunction

    task automatic fetch_pixel(input logic [9:0] col, input logic [9:0] row);
        in_item_t it;
        longint   src;
        src = chosen_index(col, row);
        // the store holds garbage until written: load the pixel first if needed
        if (src < 65536 && !loaded[src[15:0]])
            load_pixel(src[15:0], 24'($urandom()));
        it.kind       = KIND_FETCH;
        it.load_index = 16'($urandom());
        it.load_red   = 8'($urandom());
        it.load_green = 8'($urandom());
        it.load_blue  = 8'($urandom());
        it.out_x      = col;
        it.out_y      = row;
        send_item(it);
    endtask

    // valid stays high over consecutive writes; caller lowers it after the last
    task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
        cfg_index <= index;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        case (index)
            REG_SOURCE_WIDTH:  width_shadow  = value;
            REG_SOURCE_HEIGHT: height_shadow = value;
            REG_TARGET_SIZE:   target_shadow = value[10:0];
            default:           ;
        endcase
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
    endtask

    // wait for every expected result, then let any trailing load finish
    task automatic settle();
        item_valid <= 1'b0;
        do @(posedge clk); while (pending_results != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // result side: random stall per transfer, plus the occasional long hold-off
    initial
    begin : drain_results
        int gap;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (holds_done < holds_wanted)
            begin
                result_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                holds_done++;
            end
            else
            begin
                gap = calm ? 0 : $urandom_range(0, MAX_GAP);
                if (gap != 0)
                begin
                    result_stall <= 1'b1;
                    repeat (gap) @(posedge clk);
                end
            end
            result_stall <= 1'b0;
            do @(posedge clk); while (!(result_valid && !result_stall));
        end
    end

    // hang detection: any transfer on any channel counts as progress
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin : make_stimulus
        int         phase;
        int         n;
        int         span;
        logic [9:0] col;
        logic [9:0] row;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset geometry: 256x256 source, 224 target, no offset
        // brightest and darkest pixels at the two corners of the output
        load_pixel(16'(chosen_index(10'd0, 10'd0)), 24'hFFFFFF);
        fetch_pixel(10'd0, 10'd0);
        load_pixel(16'(chosen_index(10'd223, 10'd223)), 24'h000000);
        fetch_pixel(10'd223, 10'd223);
        // bytes close to the channel means, rounding around zero
        load_pixel(16'(chosen_index(10'd100, 10'd37)), 24'h7B7568);
        fetch_pixel(10'd100, 10'd37);
        // top store entry
        load_pixel(16'hFFFF, 24'hA55AC3);
        // coordinates at and past the target size
        fetch_pixel(10'd224, 10'd5);
        fetch_pixel(10'd7, 10'd224);
        fetch_pixel(10'd1023, 10'd1023);

        // very wide, two rows: the lower row lands past the end of the store
        settle();
        write_reg(REG_SOURCE_WIDTH, 16'hFFFF);
        write_reg(REG_SOURCE_HEIGHT, 16'd2);
        write_reg(REG_TARGET_SIZE, 16'd1024);
        cfg_valid <= 1'b0;
        fetch_pixel(10'd0, 10'd0);
        fetch_pixel(10'd1023, 10'd0);
        fetch_pixel(10'd0, 10'd1023);
        fetch_pixel(10'd1023, 10'd1023);

        // zero sizes behave as one; unknown register index is dropped
        settle();
        write_reg(REG_SOURCE_WIDTH, 16'd0);
        write_reg(REG_SOURCE_HEIGHT, 16'd0);
        write_reg(REG_TARGET_SIZE, 16'd0);
        write_reg(REG_UNUSED, 16'h1234);
        cfg_valid <= 1'b0;
        fetch_pixel(10'd0, 10'd0);
        fetch_pixel(10'd1, 10'd1);
        fetch_pixel(10'd0, 10'd1023);

        // random phases, each with its own geometry
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            settle();
            case (phase)
                0:
                begin
                    write_reg(REG_SOURCE_WIDTH, 16'd1);
                    write_reg(REG_SOURCE_HEIGHT, 16'd1);
                    write_reg(REG_TARGET_SIZE, 16'd1);
                end
                1:
                begin
                    write_reg(REG_SOURCE_WIDTH, 16'hFFFF);
                    write_reg(REG_SOURCE_HEIGHT, 16'hFFFF);
                    write_reg(REG_TARGET_SIZE, 16'd1024);
                end
                2:
                begin
                    write_reg(REG_SOURCE_WIDTH, 16'd1);
                    write_reg(REG_SOURCE_HEIGHT, 16'hFFFF);
                    write_reg(REG_TARGET_SIZE, 16'($urandom_range(1, 1024)));
                end
                3:
                begin
                    write_reg(REG_SOURCE_WIDTH, 16'd640);
                    write_reg(REG_SOURCE_HEIGHT, 16'd480);
                    write_reg(REG_TARGET_SIZE, 16'd224);
                end
                4:
                begin
                    // upper data bits of the target write fall away
                    write_reg(REG_SOURCE_WIDTH, 16'd300);
                    write_reg(REG_SOURCE_HEIGHT, 16'd5000);
                    write_reg(REG_TARGET_SIZE, 16'hFFFF);
                end
                default:
                begin
                    write_reg(REG_SOURCE_WIDTH, 16'($urandom_range(1, 300)));
                    write_reg(REG_SOURCE_HEIGHT, 16'($urandom_range(1, 300)));
                    write_reg(REG_TARGET_SIZE, 16'($urandom_range(1, 1024)));
                end
            endcase
            cfg_valid <= 1'b0;

            // back-to-back phases; the first one also gets the long receiver hold-off
            calm <= (phase == 3 || phase == 7);
            if (phase == 3)
                holds_wanted <= holds_wanted + 1;

            n = items_sent;
            while (items_sent - n < ITEMS_PER_PHASE)
            begin
                if ($urandom_range(0, 99) < LOAD_PERCENT)
                    load_pixel(16'($urandom()), 24'($urandom()));
                else
                begin
                    // mostly inside the target square, some anywhere in the field
                    span = (target_shadow == 0) ? 1 : int'(target_shadow);
                    if (span > 1024)
                        span = 1024;
                    if ($urandom_range(0, 99) < OUTSIDE_PERCENT)
                    begin
                        col = 10'($urandom());
                        row = 10'($urandom());
                    end
                    else
                    begin
                        col = 10'($urandom_range(0, span - 1));
                        row = 10'($urandom_range(0, span - 1));
                    end
                    fetch_pixel(col, row);
                end
            end
        end

        settle();
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
